// ===== hdl/nth_regular_number_generator_macros.svh =====
// Assertion macros used by the block's top-level RTL
`ifndef NTH_REGULAR_NUMBER_GENERATOR_MACROS_SVH
`define NTH_REGULAR_NUMBER_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define NRG_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// pre in one cycle implies post in the next
`define NRG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);
`else
`define NRG_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define NRG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== hdl/nrg_pkg.sv =====
package nrg_pkg;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_RESULT
    } t_state;

    // which of the three merge pointers
    typedef enum logic [1:0] {
        LANE_TWO,
        LANE_THREE,
        LANE_FIVE
    } t_lane;

    // one flag per pointer
    typedef struct packed {
        logic five;
        logic three;
        logic two;
    } t_lane_mask;

    localparam int unsigned INDEX_W = 12;
    localparam int unsigned OUT_W   = 63;

    localparam int unsigned MUL_TWO   = 2;
    localparam int unsigned MUL_THREE = 3;
    localparam int unsigned MUL_FIVE  = 5;

endpackage

// ===== hdl/nrg_table.sv =====
module nrg_table
    import nrg_pkg::*;
#(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/nrg_merge.sv =====
module nrg_merge
    import nrg_pkg::*;
#(
    parameter int unsigned WIDTH = 64
) (
    input  logic [WIDTH-1:0] i_rdata,
    input  t_lane            i_sel,
    input  logic [WIDTH-1:0] i_prod_two,
    input  logic [WIDTH-1:0] i_prod_three,
    input  logic [WIDTH-1:0] i_prod_five,
    output logic [WIDTH-1:0] o_scaled,
    output logic [WIDTH-1:0] o_min,
    output t_lane_mask       o_hit
);

    localparam logic [WIDTH-1:0] VMAX      = '1;
    localparam logic [WIDTH-1:0] LIM_TWO   = VMAX / MUL_TWO;
    localparam logic [WIDTH-1:0] LIM_THREE = VMAX / MUL_THREE;
    localparam logic [WIDTH-1:0] LIM_FIVE  = VMAX / MUL_FIVE;

    logic [WIDTH-1:0] sat_two;
    logic [WIDTH-1:0] sat_three;
    logic [WIDTH-1:0] sat_five;
    logic [WIDTH-1:0] min_a;

    // saturating constant multiplies of the fetched word
    assign sat_two   = (i_rdata > LIM_TWO)   ? VMAX : i_rdata * WIDTH'(MUL_TWO);
    assign sat_three = (i_rdata > LIM_THREE) ? VMAX : i_rdata * WIDTH'(MUL_THREE);
    assign sat_five  = (i_rdata > LIM_FIVE)  ? VMAX : i_rdata * WIDTH'(MUL_FIVE);

    always_comb begin
        unique case (i_sel)
            LANE_TWO:   o_scaled = sat_two;
            LANE_THREE: o_scaled = sat_three;
            LANE_FIVE:  o_scaled = sat_five;
            default:    o_scaled = sat_two;
        endcase
    end

    // least of the cached products and which pointers match it
    assign min_a = (i_prod_three < i_prod_two) ? i_prod_three : i_prod_two;
    assign o_min = (i_prod_five < min_a) ? i_prod_five : min_a;

    assign o_hit.two   = (i_prod_two   == o_min);
    assign o_hit.three = (i_prod_three == o_min);
    assign o_hit.five  = (i_prod_five  == o_min);

endmodule

// ===== hdl/nth_regular_number_generator.sv =====
// Index zero or beyond the table: the result is zero and no table read is made.
// Index already in the table: one table read in ST_CHECK, then ST_RESULT.
// Each missing entry costs one append in ST_CHECK plus a ST_CHECK/ST_FETCH pair
// per pointer refetch (usually one); refetches are serialised on the table's
// single read port.
// Reset clears count, pointers and handshake state; table contents stay undefined.
`include "nth_regular_number_generator_macros.svh"

module nth_regular_number_generator
    import nrg_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 2048,
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [INDEX_W-1:0] i_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [OUT_W-1:0]   o_value
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_ptr_two, n_ptr_two;
    logic [AW-1:0]          r_ptr_three, n_ptr_three;
    logic [AW-1:0]          r_ptr_five, n_ptr_five;
    logic [VALUE_WIDTH-1:0] r_prod_two, n_prod_two;
    logic [VALUE_WIDTH-1:0] r_prod_three, n_prod_three;
    logic [VALUE_WIDTH-1:0] r_prod_five, n_prod_five;
    t_lane_mask             r_need, n_need;
    t_lane                  r_sel, n_sel;
    logic [INDEX_W-1:0]     r_idx, n_idx;
    logic                   r_zero, n_zero;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_W-1:0]       r_value, n_value;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    logic [VALUE_WIDTH-1:0] scaled;
    logic [VALUE_WIDTH-1:0] merge_min;
    t_lane_mask             merge_hit;
    logic [63:0]            rdata_ext;
    logic [12:0]            in_idx_ext;
    logic [12:0]            idx_ext;
    logic [12:0]            count_ext;
    logic                   out_busy;
    logic                   ptr_in_fill;
    logic                   count_ok;
    logic                   fetch_ok;

    nrg_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    nrg_merge #(
        .WIDTH (VALUE_WIDTH)
    ) u_merge (
        .i_rdata      (mem_rdata),
        .i_sel        (r_sel),
        .i_prod_two   (r_prod_two),
        .i_prod_three (r_prod_three),
        .i_prod_five  (r_prod_five),
        .o_scaled     (scaled),
        .o_min        (merge_min),
        .o_hit        (merge_hit)
    );

    assign rdata_ext  = 64'(mem_rdata);
    assign in_idx_ext = 13'(i_index);
    assign idx_ext    = 13'(r_idx);
    assign count_ext  = 13'(r_count);
    assign out_busy   = r_out_valid && i_stall;

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_value = r_value;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ptr_two   <= '0;
            r_ptr_three <= '0;
            r_ptr_five  <= '0;
            r_need      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr_two   <= n_ptr_two;
            r_ptr_three <= n_ptr_three;
            r_ptr_five  <= n_ptr_five;
            r_need      <= n_need;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod_two   <= n_prod_two;
        r_prod_three <= n_prod_three;
        r_prod_five  <= n_prod_five;
        r_sel        <= n_sel;
        r_idx        <= n_idx;
        r_zero       <= n_zero;
        r_value      <= n_value;
    end

    // sequencer: fetch stale pointer products, append entries, read result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr_two    = r_ptr_two;
        n_ptr_three  = r_ptr_three;
        n_ptr_five   = r_ptr_five;
        n_prod_two   = r_prod_two;
        n_prod_three = r_prod_three;
        n_prod_five  = r_prod_five;
        n_need       = r_need;
        n_sel        = r_sel;
        n_idx        = r_idx;
        n_zero       = r_zero;
        n_value      = r_value;
        n_out_valid  = out_busy;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_idx = i_index;
                    if (i_index == '0 || in_idx_ext > 13'(TABLE_DEPTH)) begin
                        n_zero  = 1'b1;
                        n_state = ST_RESULT;
                    end else begin
                        n_zero  = 1'b0;
                        n_state = ST_CHECK;
                        // seed the table with 1 on first use
                        if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = VALUE_WIDTH'(1);
                            n_count   = CW'(1);
                            n_need    = '1;
                        end
                    end
                end
            end

            ST_CHECK: begin
                if (count_ext >= idx_ext) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_idx - INDEX_W'(1));
                    n_state   = ST_RESULT;
                end else if (r_need != '0) begin
                    mem_re  = 1'b1;
                    n_state = ST_FETCH;
                    priority if (r_need.two) begin
                        n_sel     = LANE_TWO;
                        mem_raddr = r_ptr_two;
                    end else if (r_need.three) begin
                        n_sel     = LANE_THREE;
                        mem_raddr = r_ptr_three;
                    end else begin
                        n_sel     = LANE_FIVE;
                        mem_raddr = r_ptr_five;
                    end
                end else begin
                    // append the least product, advance matching pointers
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_count);
                    mem_wdata = merge_min;
                    n_count   = r_count + CW'(1);
                    n_need    = merge_hit;
                    if (merge_hit.two) begin
                        n_ptr_two = r_ptr_two + AW'(1);
                    end
                    if (merge_hit.three) begin
                        n_ptr_three = r_ptr_three + AW'(1);
                    end
                    if (merge_hit.five) begin
                        n_ptr_five = r_ptr_five + AW'(1);
                    end
                end
            end

            ST_FETCH: begin
                n_state = ST_CHECK;
                unique case (r_sel)
                    LANE_TWO: begin
                        n_prod_two = scaled;
                        n_need.two = 1'b0;
                    end
                    LANE_THREE: begin
                        n_prod_three = scaled;
                        n_need.three = 1'b0;
                    end
                    LANE_FIVE: begin
                        n_prod_five = scaled;
                        n_need.five = 1'b0;
                    end
                    default: begin
                        n_need = r_need;
                    end
                endcase
            end

            ST_RESULT: begin
                // load output register once the previous word has left
                if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_value     = r_zero ? '0 : rdata_ext[OUT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // check terms
    assign ptr_in_fill = (r_count == '0) ||
                         ((CW+1)'(r_ptr_two)   < (CW+1)'(r_count) &&
                          (CW+1)'(r_ptr_three) < (CW+1)'(r_count) &&
                          (CW+1)'(r_ptr_five)  < (CW+1)'(r_count));
    assign count_ok    = (count_ext <= 13'(TABLE_DEPTH));
    assign fetch_ok    = (r_state != ST_FETCH) ||
                         (r_sel == LANE_TWO   && r_need.two)   ||
                         (r_sel == LANE_THREE && r_need.three) ||
                         (r_sel == LANE_FIVE  && r_need.five);

    // checks
    `NRG_ASSERT_ALWAYS(a_ptr_below_count, i_clk, i_rst_n, ptr_in_fill, "pointer past fill")
    `NRG_ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, count_ok, "fill count past depth")
    `NRG_ASSERT_NEXT(a_count_monotonic, i_clk, i_rst_n, 1'b1, r_count >= $past(r_count), "count fell")
    `NRG_ASSERT_ALWAYS(a_fetch_needed, i_clk, i_rst_n, fetch_ok, "fetch of fresh pointer")

endmodule

// ===== dv/tb_nth_regular_number_generator.sv =====
module tb_nth_regular_number_generator;
    import nrg_pkg::*;

    localparam int unsigned SEQ_DEPTH      = 2048;
    localparam int unsigned WATCHDOG_LIMIT = 40000;
    localparam int unsigned TAIL_CYCLES    = 64;
    localparam int unsigned RANDOM_WORDS   = 116;
    localparam int unsigned REPORT_LIMIT   = 10;

    // Tracks the 5-smooth sequence and the values owed by the block
    class regular_seq_scoreboard;
        logic [63:0] seq_table [SEQ_DEPTH];
        bit [11:0]   filled;
        bit [10:0]   ptr_two;
        bit [10:0]   ptr_three;
        bit [10:0]   ptr_five;
        bit [OUT_W-1:0] owed_values [$];
        int unsigned fail_count;

        function new();
            filled     = '0;
            ptr_two    = '0;
            ptr_three  = '0;
            ptr_five   = '0;
            fail_count = 0;
        endfunction

        // product clamped to the all-ones 64-bit value
        function logic [63:0] clamp_times(logic [63:0] a, int unsigned k);
            logic [66:0] prod;
            prod = {3'b000, a} * k;
            if (prod[66:64] != 3'b000)
                return '1;
            return prod[63:0];
        endfunction

        // one step of the three-pointer merge
        function void grow_sequence();
            logic [63:0] by2, by3, by5, least;
            by2 = clamp_times(seq_table[ptr_two], MUL_TWO);
            by3 = clamp_times(seq_table[ptr_three], MUL_THREE);
            by5 = clamp_times(seq_table[ptr_five], MUL_FIVE);
            least = by2;
            if (by3 < least)
                least = by3;
            if (by5 < least)
                least = by5;
            seq_table[filled[10:0]] = least;
            filled = filled + 1'b1;
            if (by2 == least)
                ptr_two = ptr_two + 1'b1;
            if (by3 == least)
                ptr_three = ptr_three + 1'b1;
            if (by5 == least)
                ptr_five = ptr_five + 1'b1;
        endfunction

        // accepted request word: work out the value it should return
        function void note_request(bit [INDEX_W-1:0] idx);
            bit [OUT_W-1:0] want;
            if (idx == 0 || idx > SEQ_DEPTH) begin
                want = '0;
            end else begin
                if (filled == 0) begin
                    seq_table[0] = 64'd1;
                    filled = 12'd1;
                end
                while (filled < idx)
                    grow_sequence();
                want = seq_table[idx - 1][OUT_W-1:0];
            end
            owed_values.push_back(want);
        endfunction

        function void flag(string what);
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("ERROR @%0t: %s", $time, what);
        endfunction

        // accepted result word: compare with the oldest owed value
        function void check_value(bit [OUT_W-1:0] got);
            bit [OUT_W-1:0] want;
            if (owed_values.size() == 0) begin
                flag($sformatf("unexpected result value=%0d", got));
                return;
            end
            want = owed_values.pop_front();
            if (got !== want)
                flag($sformatf("value mismatch: expected %0d, actual %0d", want, got));
        endfunction

        function int unsigned owed_count();
            return owed_values.size();
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [INDEX_W-1:0] i_index = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [OUT_W-1:0]   o_value;

    regular_seq_scoreboard sb = new();
    int unsigned idle_cycles = 0;
    int unsigned frontier    = 0;
    int unsigned burst_left  = 0;

    nth_regular_number_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_index (i_index),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_value (o_value)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stall: a randomly redrawn mode selects no stall, random, patterned or heavy stall
    int unsigned rx_cycle = 0;
    int unsigned rx_mode  = 0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 50 == 0)
            rx_mode <= $urandom_range(3);
        case (rx_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(1) == 1);
            2: i_stall <= ((rx_cycle % 7) < 3);
            default: i_stall <= ($urandom_range(3) != 0);
        endcase
    end

    // monitor both handshakes and run the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_value(o_value);
            if (i_valid && !o_stall)
                sb.note_request(i_index);
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("FAIL nth_regular_number_generator");
                $finish;
            end
        end
    end

    // present one request word, hold it until taken, then maybe idle
    task automatic send_word(input bit [INDEX_W-1:0] idx, input int unsigned gap);
        i_valid <= 1'b1;
        i_index <= idx;
        do @(posedge i_clk); while (o_stall);
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_index <= INDEX_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // bursty sender: gap only when a burst runs out
    task automatic send_bursty(input bit [INDEX_W-1:0] idx);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 10)
                                                   : $urandom_range(8, 1);
            gap = $urandom_range(20, 1);
        end else begin
            burst_left--;
        end
        send_word(idx, gap);
    endtask

    // hold off until every owed value has come back
    task automatic wait_drained();
        if (i_valid) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (sb.owed_count() != 0)
            @(posedge i_clk);
    endtask

    // random index: mostly grows the table a little, plus repeats and edge words
    function automatic bit [INDEX_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return INDEX_W'($urandom_range(4095, SEQ_DEPTH + 1));
        if (r < 40)
            return INDEX_W'($urandom_range(frontier, 1));
        if (r < 90) begin
            frontier = frontier + $urandom_range(40, 1);
            if (frontier > SEQ_DEPTH)
                frontier = SEQ_DEPTH;
            return INDEX_W'(frontier);
        end
        return INDEX_W'($urandom_range(SEQ_DEPTH, 1));
    endfunction

    int unsigned directed_idx [20] = '{0, 1, 1, 2, 3, 4, 5, 6, 7, 12,
                                       9, 13, 4095, 2049, 3072, 0, 25, 24, 40, 1};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, first entries, repeats, out of range, all-ones
        foreach (directed_idx[k])
            send_bursty(INDEX_W'(directed_idx[k]));
        frontier = 40;
        wait_drained();

        // random phase with one full drain halfway
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2)
                wait_drained();
            send_bursty(pick_index());
        end

        // top of the table and just past it
        send_bursty(INDEX_W'(SEQ_DEPTH));
        send_bursty(INDEX_W'(SEQ_DEPTH - 1));
        send_bursty(INDEX_W'(SEQ_DEPTH + 1));
        send_word(INDEX_W'(1), 1);

        while (sb.owed_count() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.owed_count() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.owed_count()));

        if (sb.fail_count == 0)
            $display("PASS nth_regular_number_generator");
        else
            $display("FAIL nth_regular_number_generator");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nrg_pkg.sv
hdl/nrg_table.sv
hdl/nrg_merge.sv
hdl/nth_regular_number_generator.sv
dv/tb_nth_regular_number_generator.sv
